// File: rtl/core/rtph_pkg.sv
// Shared types, constants and codes of the RTP H.264 packetizer.
package rtph_pkg;

	localparam int MAX_PAYLOAD = 1024;
	localparam int PAY_LOG     = $clog2(MAX_PAYLOAD);
	localparam int MAX_RESULTS = 34;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);
	localparam int FRAG_W      = 16 - PAY_LOG;
	localparam int TOT_W       = ((FRAG_W > RES_W) ? FRAG_W : RES_W) + 1;

	localparam int DIV_W     = 24;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [4:0]       FU_A_TYPE      = 5'd28;
	localparam logic [7:0]       NAL_TYPE_MASK  = 8'h1F;
	localparam logic [DIV_W-1:0] AUDIO_TICKS    = 24'd1000000;
	localparam logic [DIV_W-1:0] AUDIO_RATE_DEF = 24'd8000;
	localparam logic [DIV_W-1:0] VIDEO_RATE_DEF = 24'd90000;
	localparam logic [7:0]       FPS_DEF        = 8'd25;

	localparam logic [1:0] CFG_AUTO  = 2'd0;
	localparam logic [1:0] CFG_SRATE = 2'd1;
	localparam logic [1:0] CFG_FRATE = 2'd2;

	typedef enum logic [1:0] {
		KIND_EXT    = 2'd0,
		KIND_SINGLE = 2'd1,
		KIND_FUA    = 2'd2,
		KIND_AUDIO  = 2'd3
	} pkt_kind_t;

	typedef enum logic [1:0] {
		BODY_NONE,
		BODY_AUDIO,
		BODY_SINGLE,
		BODY_FRAG
	} body_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_CLASS,
		F_PUSH
	} front_state_t;

	// one frame's packet plan, front to back
	typedef struct packed {
		logic [31:0]       stamp;
		logic [15:0]       seq_base;
		logic              has_ext;
		logic              ext_marker;
		logic [14:0]       ext_len;
		body_t             body;
		logic [7:0]        nalu;
		logic [2:0]        off_base;
		logic [14:0]       body_len;
		logic [FRAG_W-1:0] frag_cnt;
		logic [RES_W-1:0]  pkt_n;
		logic              over;
	} cmd_t;

	typedef struct packed {
		logic [15:0] seq;
		logic [31:0] stamp;
		logic        marker;
		logic        ext_flag;
		pkt_kind_t   pkt_kind;
		logic [7:0]  prefix_a;
		logic [7:0]  prefix_b;
		logic [14:0] pay_offset;
		logic [14:0] pay_len;
		logic        too_long;
		logic        last;
	} pkt_t;

endpackage

// File: rtl/core/rtph_front.sv
// Front end: accepts frame words, keeps timestamp and sequence state, plans packets.
module rtph_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [14:0]       frame_len,
	input  logic [39:0]       lead_bytes,
	input  logic [31:0]       frame_stamp,
	input  logic [15:0]       ext_len,
	output logic              push,
	output rtph_pkg::cmd_t    push_data,
	input  logic              full
);

	rtph_pkg::front_state_t state_q, state_d;

	logic        auto_q;
	logic [23:0] srate_q;
	logic [7:0]  frate_q;
	logic        started_q;
	logic [31:0] stamp_q;
	logic [15:0] vseq_q;
	logic [15:0] aseq_q;

	logic        req_type_q;
	logic [14:0] size_q;
	logic [39:0] lead_q;
	logic [15:0] elen_q;

	logic [rtph_pkg::DIV_W-1:0]     div_rem_q;
	logic [rtph_pkg::DIV_W-1:0]     div_quo_q;
	logic [rtph_pkg::DIV_W-1:0]     div_den_q;
	logic [rtph_pkg::DIV_CNT_W-1:0] div_cnt_q;

	logic [rtph_pkg::DIV_W:0]   rem_sh;
	logic [rtph_pkg::DIV_W:0]   rem_sub;
	logic                       div_ge;
	logic [rtph_pkg::DIV_W-1:0] rem_nxt;
	logic [rtph_pkg::DIV_W-1:0] quo_nxt;
	logic                       div_done;

	logic [23:0] srate_eff;
	logic [7:0]  frate_eff;

	rtph_pkg::cmd_t cmd_q, cmd_d;

	logic accept;

	assign accept = in_valid && in_ready;

	// restoring divider, one quotient bit per cycle
	assign rem_sh   = {div_rem_q, div_quo_q[rtph_pkg::DIV_W-1]};
	assign rem_sub  = rem_sh - {1'b0, div_den_q};
	assign div_ge   = rem_sh >= {1'b0, div_den_q};
	assign rem_nxt  = div_ge ? rem_sub[rtph_pkg::DIV_W-1:0] : rem_sh[rtph_pkg::DIV_W-1:0];
	assign quo_nxt  = {div_quo_q[rtph_pkg::DIV_W-2:0], div_ge};
	assign div_done = div_cnt_q == rtph_pkg::DIV_CNT_W'(rtph_pkg::DIV_W - 1);

	assign srate_eff = (srate_q != 24'd0) ? srate_q :
		(req_type ? rtph_pkg::VIDEO_RATE_DEF : rtph_pkg::AUDIO_RATE_DEF);
	assign frate_eff = (frate_q != 8'd0) ? frate_q : rtph_pkg::FPS_DEF;

	// packet plan from the latched frame word
	always_comb begin
		logic [7:0]                  b0, b1, b2, b3, b4;
		logic                        pos3, pos4, vid_ok, single;
		logic [2:0]                  pos;
		logic [14:0]                 dsz;
		logic [rtph_pkg::PAY_LOG-1:0] rem_l;
		logic [rtph_pkg::FRAG_W-1:0]  frag_cnt, body_cnt;
		logic [rtph_pkg::TOT_W-1:0]   total;
		logic                        has_ext;
		b0 = lead_q[39:32];
		b1 = lead_q[31:24];
		b2 = lead_q[23:16];
		b3 = lead_q[15:8];
		b4 = lead_q[7:0];
		pos3 = (b0 == 8'd0) && (b1 == 8'd0) && (b2 == 8'd1);
		pos4 = !pos3 && (b0 == 8'd0) && (b1 == 8'd0) && (b2 == 8'd0) && (b3 == 8'd1);
		pos = pos3 ? 3'd3 : 3'd4;
		vid_ok = (size_q > 15'd4) && (pos3 || pos4);
		dsz = size_q - {12'd0, pos};
		single = dsz <= 15'(rtph_pkg::MAX_PAYLOAD);
		rem_l = dsz[rtph_pkg::PAY_LOG-1:0];
		frag_cnt = {1'b0, dsz[14:rtph_pkg::PAY_LOG]} +
			rtph_pkg::FRAG_W'(rem_l != '0);
		has_ext = (elen_q != 16'd0) && (elen_q < 16'(rtph_pkg::MAX_PAYLOAD));

		cmd_d            = '0;
		cmd_d.stamp      = stamp_q;
		cmd_d.seq_base   = req_type_q ? vseq_q : aseq_q;
		cmd_d.has_ext    = has_ext;
		cmd_d.ext_marker = size_q == 15'd0;
		cmd_d.ext_len    = elen_q[14:0];
		cmd_d.nalu       = pos3 ? b3 : b4;
		cmd_d.off_base   = pos + 3'd1;
		cmd_d.frag_cnt   = frag_cnt;
		body_cnt         = '0;
		if (!req_type_q) begin
			if (size_q != 15'd0) begin
				cmd_d.body     = rtph_pkg::BODY_AUDIO;
				cmd_d.body_len = size_q;
				body_cnt       = rtph_pkg::FRAG_W'(1);
			end
		end else if (vid_ok) begin
			if (single) begin
				cmd_d.body     = rtph_pkg::BODY_SINGLE;
				cmd_d.body_len = dsz - 15'd1;
				body_cnt       = rtph_pkg::FRAG_W'(1);
			end else begin
				cmd_d.body     = rtph_pkg::BODY_FRAG;
				cmd_d.body_len = (rem_l == '0) ? 15'(rtph_pkg::MAX_PAYLOAD - 1) :
					15'(rem_l) - 15'd1;
				body_cnt       = frag_cnt;
			end
		end
		total = rtph_pkg::TOT_W'(has_ext) + rtph_pkg::TOT_W'(body_cnt);
		cmd_d.over  = total > rtph_pkg::TOT_W'(rtph_pkg::MAX_RESULTS);
		cmd_d.pkt_n = cmd_d.over ? rtph_pkg::RES_W'(rtph_pkg::MAX_RESULTS) :
			total[rtph_pkg::RES_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtph_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			rtph_pkg::F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (auto_q && started_q) ? rtph_pkg::F_DIV : rtph_pkg::F_CLASS;
				end
			end
			rtph_pkg::F_DIV: begin
				if (div_done) begin
					state_d = rtph_pkg::F_CLASS;
				end
			end
			rtph_pkg::F_CLASS: begin
				state_d = (cmd_d.pkt_n != '0) ? rtph_pkg::F_PUSH : rtph_pkg::F_IDLE;
			end
			rtph_pkg::F_PUSH: begin
				push = !full;
				if (!full) begin
					state_d = rtph_pkg::F_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q    <= 1'b1;
			srate_q   <= '0;
			frate_q   <= '0;
			started_q <= 1'b0;
			stamp_q   <= '0;
			vseq_q    <= '0;
			aseq_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rtph_pkg::CFG_AUTO:  auto_q  <= cfg_data[0];
					rtph_pkg::CFG_SRATE: srate_q <= cfg_data;
					rtph_pkg::CFG_FRATE: frate_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (!auto_q) begin
					stamp_q <= frame_stamp;
				end else if (!started_q) begin
					stamp_q   <= '0;
					started_q <= 1'b1;
				end else begin
					srate_q <= srate_eff;
					if (req_type) begin
						frate_q <= frate_eff;
					end
				end
			end
			if (state_q == rtph_pkg::F_DIV && div_done) begin
				stamp_q <= stamp_q + 32'(quo_nxt);
			end
			if (state_q == rtph_pkg::F_CLASS) begin
				if (req_type_q) begin
					vseq_q <= vseq_q + 16'(cmd_d.pkt_n);
				end else begin
					aseq_q <= aseq_q + 16'(cmd_d.pkt_n);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req_type;
			size_q     <= frame_len;
			lead_q     <= lead_bytes;
			elen_q     <= ext_len;
			div_rem_q  <= '0;
			div_cnt_q  <= '0;
			div_quo_q  <= req_type ? srate_eff : rtph_pkg::AUDIO_TICKS;
			div_den_q  <= req_type ? {16'd0, frate_eff} : srate_eff;
		end else if (state_q == rtph_pkg::F_DIV) begin
			div_rem_q <= rem_nxt;
			div_quo_q <= quo_nxt;
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (state_q == rtph_pkg::F_CLASS) begin
			cmd_q <= cmd_d;
		end
	end

	assign push_data = cmd_q;

endmodule

// File: rtl/core/rtph_fifo.sv
// Two-entry queue of packet plans between front and back.
module rtph_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rtph_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output rtph_pkg::cmd_t pop_data,
	output logic           empty
);

	rtph_pkg::cmd_t mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/rtph_back.sv
// Back end: walks a packet plan and emits one packet word per cycle unless the output stalls.
module rtph_back (
	input  logic           clk,
	input  logic           arst_n,
	output logic           pop,
	input  rtph_pkg::cmd_t pop_data,
	input  logic           empty,
	output logic           out_valid,
	input  logic           out_ready,
	output rtph_pkg::pkt_t pkt
);

	rtph_pkg::cmd_t cmd_q;
	logic                       busy_q;
	logic [rtph_pkg::RES_W-1:0] idx_q;
	logic                       out_valid_q;
	rtph_pkg::pkt_t             pkt_q, pkt_d;
	logic                       load;

	assign pop  = !busy_q && !empty;
	assign load = busy_q && (!out_valid_q || out_ready);

	always_comb begin
		logic [rtph_pkg::RES_W-1:0] j;
		logic                       endf;
		j    = idx_q - rtph_pkg::RES_W'(cmd_q.has_ext);
		endf = (rtph_pkg::TOT_W'(j) + rtph_pkg::TOT_W'(1)) ==
			rtph_pkg::TOT_W'(cmd_q.frag_cnt);

		pkt_d            = '0;
		pkt_d.seq        = cmd_q.seq_base + 16'(idx_q);
		pkt_d.stamp      = cmd_q.stamp;
		pkt_d.too_long   = cmd_q.over;
		pkt_d.last       = (idx_q + 1'b1) == cmd_q.pkt_n;
		if (cmd_q.has_ext && idx_q == '0) begin
			pkt_d.marker   = cmd_q.ext_marker;
			pkt_d.ext_flag = 1'b1;
			pkt_d.pkt_kind = rtph_pkg::KIND_EXT;
			pkt_d.pay_len  = cmd_q.ext_len;
		end else begin
			unique case (cmd_q.body)
				rtph_pkg::BODY_AUDIO: begin
					pkt_d.marker   = 1'b1;
					pkt_d.pkt_kind = rtph_pkg::KIND_AUDIO;
					pkt_d.pay_len  = cmd_q.body_len;
				end
				rtph_pkg::BODY_SINGLE: begin
					pkt_d.marker     = 1'b1;
					pkt_d.pkt_kind   = rtph_pkg::KIND_SINGLE;
					pkt_d.prefix_a   = cmd_q.nalu;
					pkt_d.pay_offset = 15'(cmd_q.off_base);
					pkt_d.pay_len    = cmd_q.body_len;
				end
				rtph_pkg::BODY_FRAG: begin
					pkt_d.marker     = endf;
					pkt_d.pkt_kind   = rtph_pkg::KIND_FUA;
					pkt_d.prefix_a   = {cmd_q.nalu[7:5], rtph_pkg::FU_A_TYPE};
					pkt_d.prefix_b   = {j == '0, endf, 1'b0,
						5'(cmd_q.nalu & rtph_pkg::NAL_TYPE_MASK)};
					pkt_d.pay_offset = 15'(cmd_q.off_base) + (15'(j) << rtph_pkg::PAY_LOG);
					pkt_d.pay_len    = endf ? cmd_q.body_len : 15'(rtph_pkg::MAX_PAYLOAD);
				end
				rtph_pkg::BODY_NONE: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			cmd_q       <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				cmd_q  <= pop_data;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
				if (pkt_d.last) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pkt_q <= pkt_d;
		end
	end

	assign out_valid = out_valid_q;
	assign pkt       = pkt_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < cmd_q.pkt_n)
		else $error("packet index past plan");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		load && pkt_d.last |=> !busy_q && out_valid_q && pkt_q.last)
		else $error("plan not closed after last packet");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		load && !pkt_d.last |=> busy_q && idx_q == $past(idx_q) + 1'b1)
		else $error("packet index did not advance");

endmodule

// File: rtl/core/rtp_h264_packetizer_top.sv
// Top level of the RTP H.264 / audio packetizer: front, plan queue, back.
//
//  channel  signals                         role
//  in       in_valid / in_ready + fields    frame word in
//  out      out_valid / out_ready + fields  packet word out
//  cfg      cfg_we, cfg_index, cfg_data     register write, no wait
//
// In the front a frame word is accepted, runs the divider when the timestamp is
// generated and the frame is not the first after reset, is classified, and its plan
// is pushed (no push when it gives no packet), waiting while the plan queue is full.
// The back loads each frame's plan, then emits one packet word per cycle unless stalled.
// Reset clears sequence counters and timestamp and restores register defaults.
// A two-entry plan queue lets the front take frames while the output is stalled.
module rtp_h264_packetizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [14:0] frame_len,
	input  logic [39:0] lead_bytes,
	input  logic [31:0] frame_stamp,
	input  logic [15:0] ext_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] seq,
	output logic [31:0] stamp,
	output logic        marker,
	output logic        ext_flag,
	output logic [1:0]  pkt_kind,
	output logic [7:0]  prefix_a,
	output logic [7:0]  prefix_b,
	output logic [14:0] pay_offset,
	output logic [14:0] pay_len,
	output logic        too_long,
	output logic        last
);

	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	rtph_pkg::cmd_t push_data;
	rtph_pkg::cmd_t pop_data;
	rtph_pkg::pkt_t pkt;

	rtph_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.frame_len   (frame_len),
		.lead_bytes  (lead_bytes),
		.frame_stamp (frame_stamp),
		.ext_len     (ext_len),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	rtph_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	rtph_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pkt       (pkt)
	);

	assign seq        = pkt.seq;
	assign stamp      = pkt.stamp;
	assign marker     = pkt.marker;
	assign ext_flag   = pkt.ext_flag;
	assign pkt_kind   = pkt.pkt_kind;
	assign prefix_a   = pkt.prefix_a;
	assign prefix_b   = pkt.prefix_b;
	assign pay_offset = pkt.pay_offset;
	assign pay_len    = pkt.pay_len;
	assign too_long   = pkt.too_long;
	assign last       = pkt.last;

endmodule
